// ===== hdl/sorted_priority_queue_unit_macros.svh =====
// Assertion helpers shared by the checker
`ifndef SORTED_PRIORITY_QUEUE_UNIT_MACROS_SVH
`define SORTED_PRIORITY_QUEUE_UNIT_MACROS_SVH

// clocked property, switched off while reset is held
`define SPQU_ASSERT(lbl, clk, rst_n, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) \
        else $error(msg);

// clocked property that also holds through reset
`define SPQU_ASSERT_ALWAYS(lbl, clk, prop, msg) \
    lbl: assert property (@(posedge clk) prop) \
        else $error(msg);

`endif

// ===== hdl/spqu_pkg.sv =====
package spqu_pkg;

    localparam int DEFAULT_DEPTH = 64;
    localparam int DATA_W        = 32;
    localparam int OCC_W         = 7;

    typedef enum logic {
        OP_INSERT  = 1'b0,
        OP_EXTRACT = 1'b1
    } t_opcode;

    typedef enum logic [1:0] {
        ST_DONE  = 2'd0,
        ST_FULL  = 2'd1,
        ST_EMPTY = 2'd2
    } t_status;

    typedef struct packed {
        logic                     valid;
        logic signed [DATA_W-1:0] val;
        logic signed [DATA_W-1:0] prio;
    } t_entry;

    // broadcast to every cell in the chain
    typedef struct packed {
        logic                     ins;
        logic                     ext;
        logic signed [DATA_W-1:0] val;
        logic signed [DATA_W-1:0] prio;
    } t_cell_ctrl;

endpackage

// ===== hdl/sorted_priority_queue_unit.sv =====
// Sorted priority queue built as a chain of compare-and-shift cells.
// Result strobe o_done is registered at the accepting edge and shows in the cycle after it.
// Throughput: one item per cycle; every cell compares and shifts in parallel.
// busy stays low; the receiver cannot stall, results show for one cycle.
// Reset (synchronous, active low) empties the queue; entry data is not cleared.
module sorted_priority_queue_unit
    import spqu_pkg::*;
#(
    parameter int DEPTH = DEFAULT_DEPTH
) (
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    input  logic                     start,
    output logic                     busy,
    input  logic                     i_opcode,
    input  logic signed [DATA_W-1:0] i_in_value,
    input  logic signed [DATA_W-1:0] i_in_priority,
    output logic                     o_done,
    output logic [1:0]               o_status,
    output logic signed [DATA_W-1:0] o_out_value,
    output logic signed [DATA_W-1:0] o_out_priority,
    output logic [OCC_W-1:0]         o_occupancy
);

    localparam int CNT_W = $clog2(DEPTH + 1);

    t_entry     w_entry [DEPTH];
    logic       w_p     [DEPTH];
    t_cell_ctrl w_ctrl;

    logic                     accept;
    logic                     full;
    logic                     empty;
    logic [CNT_W-1:0]         r_count;
    logic [CNT_W-1:0]         n_count;
    logic                     r_done;
    t_status                  r_status;
    t_status                  n_status;
    logic signed [DATA_W-1:0] r_value;
    logic signed [DATA_W-1:0] n_value;
    logic signed [DATA_W-1:0] r_prio;
    logic signed [DATA_W-1:0] n_prio;

    assign busy   = 1'b0;
    assign accept = start && !busy;
    assign empty  = !w_entry[0].valid;
    assign full   = w_entry[DEPTH-1].valid;

    assign w_ctrl.ins  = accept && (t_opcode'(i_opcode) == OP_INSERT) && !full;
    assign w_ctrl.ext  = accept && (t_opcode'(i_opcode) == OP_EXTRACT) && !empty;
    assign w_ctrl.val  = i_in_value;
    assign w_ctrl.prio = i_in_priority;

    for (genvar g = 0; g < DEPTH; g++) begin : g_cell
        t_entry left_e;
        t_entry right_e;
        logic   left_p;

        if (g == 0) begin : g_head
            assign left_e = '0;
            assign left_p = 1'b0;
        end else begin : g_mid
            assign left_e = w_entry[g-1];
            assign left_p = w_p[g-1];
        end

        if (g == DEPTH - 1) begin : g_tail
            assign right_e = '0;
        end else begin : g_body
            assign right_e = w_entry[g+1];
        end

        spqu_cell u_cell (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_ctrl  (w_ctrl),
            .i_left  (left_e),
            .i_left_p(left_p),
            .i_right (right_e),
            .o_entry (w_entry[g]),
            .o_p     (w_p[g])
        );
    end

    always_comb begin
        n_count  = r_count;
        n_status = ST_DONE;
        n_value  = '0;
        n_prio   = '0;
        if (t_opcode'(i_opcode) == OP_INSERT) begin
            if (full) begin
                n_status = ST_FULL;
            end else begin
                n_count = r_count + CNT_W'(1);
            end
        end else begin
            if (empty) begin
                n_status = ST_EMPTY;
            end else begin
                n_value = w_entry[0].val;
                n_prio  = w_entry[0].prio;
                n_count = r_count - CNT_W'(1);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count <= '0;
            r_done  <= 1'b0;
        end else begin
            r_done <= accept;
            if (accept) begin
                r_count <= n_count;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_status <= n_status;
            r_value  <= n_value;
            r_prio   <= n_prio;
        end
    end

    assign o_done         = r_done;
    assign o_status       = r_status;
    assign o_out_value    = r_value;
    assign o_out_priority = r_prio;
    assign o_occupancy    = OCC_W'(r_count);

endmodule

// ===== hdl/spqu_cell.sv =====
module spqu_cell
    import spqu_pkg::*;
(
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  t_cell_ctrl i_ctrl,
    input  t_entry     i_left,
    input  logic       i_left_p,
    input  t_entry     i_right,
    output t_entry     o_entry,
    output logic       o_p
);

    logic   r_valid;
    logic   n_valid;
    t_entry r_data;
    t_entry n_data;

    // at or past the insertion point: empty slot or strictly larger priority
    assign o_p = !r_valid || (r_data.prio > i_ctrl.prio);

    always_comb begin
        n_data  = r_data;
        n_valid = r_valid;
        if (i_ctrl.ins) begin
            if (i_left_p) begin
                n_data  = i_left;
                n_valid = i_left.valid;
            end else if (o_p) begin
                n_data.val  = i_ctrl.val;
                n_data.prio = i_ctrl.prio;
                n_valid     = 1'b1;
            end
        end else if (i_ctrl.ext) begin
            n_data  = i_right;
            n_valid = i_right.valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else begin
            r_valid <= n_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_data <= n_data;
    end

    always_comb begin
        o_entry       = r_data;
        o_entry.valid = r_valid;
    end

endmodule

// ===== hdl/spqu_checker.sv =====
`include "sorted_priority_queue_unit_macros.svh"

module spqu_assertions
    import spqu_pkg::*;
#(
    parameter int DEPTH = DEFAULT_DEPTH
) (
    input logic                     i_clk,
    input logic                     i_rst_n,
    input logic                     start,
    input logic                     busy,
    input logic                     o_done,
    input logic [1:0]               o_status,
    input logic signed [DATA_W-1:0] o_out_value,
    input logic signed [DATA_W-1:0] o_out_priority,
    input logic [OCC_W-1:0]         o_occupancy
);

    logic beat;
    logic refused;
    logic zero_data;
    logic full_ref;
    logic empty_ref;
    logic at_depth;
    logic no_entries;

    assign beat       = start && !busy;
    assign refused    = o_done && (o_status != ST_DONE);
    assign zero_data  = (o_out_value == '0) && (o_out_priority == '0);
    assign full_ref   = o_done && (o_status == ST_FULL);
    assign empty_ref  = o_done && (o_status == ST_EMPTY);
    assign at_depth   = (o_occupancy == OCC_W'(DEPTH));
    assign no_entries = (o_occupancy == '0);

    // every accepted beat gives exactly one result on the next cycle
    `SPQU_ASSERT(a_result_follows, i_clk, i_rst_n, beat |=> o_done, "missing result")
    `SPQU_ASSERT(a_no_stray_result, i_clk, i_rst_n, !beat |=> !o_done, "stray result")
    `SPQU_ASSERT(a_refused_zero, i_clk, i_rst_n, refused |-> zero_data, "refused item data")
    `SPQU_ASSERT(a_full_occ, i_clk, i_rst_n, full_ref |-> at_depth, "full refusal below depth")
    `SPQU_ASSERT(a_empty_occ, i_clk, i_rst_n, empty_ref |-> no_entries, "empty refusal with data")

endmodule

bind sorted_priority_queue_unit spqu_assertions #(.DEPTH(DEPTH)) u_spqu_assertions (
    .i_clk         (i_clk),
    .i_rst_n       (i_rst_n),
    .start         (start),
    .busy          (busy),
    .o_done        (o_done),
    .o_status      (o_status),
    .o_out_value   (o_out_value),
    .o_out_priority(o_out_priority),
    .o_occupancy   (o_occupancy)
);

// ===== tb/spqu_checker.sv =====
module spqu_checker
    import spqu_pkg::*;
#(
    parameter int DEPTH = DEFAULT_DEPTH
) (
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    input  logic                     start,
    input  logic                     busy,
    input  logic                     i_opcode,
    input  logic signed [DATA_W-1:0] i_in_value,
    input  logic signed [DATA_W-1:0] i_in_priority,
    input  logic                     o_done,
    input  logic [1:0]               o_status,
    input  logic signed [DATA_W-1:0] o_out_value,
    input  logic signed [DATA_W-1:0] o_out_priority,
    input  logic [OCC_W-1:0]         o_occupancy,
    output int                       n_fail,
    output int                       n_pending
);

    localparam int MAX_PRINTED = 100;

    typedef struct {
        logic signed [DATA_W-1:0] val;
        logic signed [DATA_W-1:0] prio;
    } t_slot;

    typedef struct {
        t_status                  status;
        logic signed [DATA_W-1:0] val;
        logic signed [DATA_W-1:0] prio;
        logic [OCC_W-1:0]         occ;
    } t_outcome;

    // front of the queue is the next entry to be served
    t_slot    stored_entries[$];
    t_outcome awaited_results[$];

    initial begin
        n_fail    = 0;
        n_pending = 0;
    end

    function automatic t_outcome apply_queue_op(t_opcode op,
                                                logic signed [DATA_W-1:0] val,
                                                logic signed [DATA_W-1:0] prio);
        t_outcome res;
        t_slot    s;
        int       k;
        res.status = ST_DONE;
        res.val    = '0;
        res.prio   = '0;
        if (op == OP_INSERT) begin
            if (stored_entries.size() >= DEPTH) begin
                res.status = ST_FULL;
            end else begin
                // ties go behind stored entries: skip only strictly greater ones
                k = stored_entries.size();
                while (k > 0 && stored_entries[k-1].prio > prio)
                    k--;
                s.val  = val;
                s.prio = prio;
                stored_entries.insert(k, s);
            end
        end else begin
            if (stored_entries.size() == 0) begin
                res.status = ST_EMPTY;
            end else begin
                s        = stored_entries.pop_front();
                res.val  = s.val;
                res.prio = s.prio;
            end
        end
        res.occ = OCC_W'(stored_entries.size());
        return res;
    endfunction

    task automatic report_mismatch(string field, logic [DATA_W-1:0] got,
                                   logic [DATA_W-1:0] want);
        n_fail++;
        if (n_fail <= MAX_PRINTED)
            $display("[%0t] mismatch on %s: got %h, want %h", $time, field, got, want);
    endtask

    always @(posedge i_clk) begin : monitor
        t_outcome want;
        if (i_rst_n) begin
            // result of the previous beat is checked before this edge's beat is predicted
            if (o_done) begin
                if (awaited_results.size() == 0) begin
                    report_mismatch("unexpected result", DATA_W'(o_occupancy), '0);
                end else begin
                    want = awaited_results.pop_front();
                    if (o_status !== want.status)
                        report_mismatch("status", DATA_W'(o_status), DATA_W'(want.status));
                    if (o_out_value !== want.val)
                        report_mismatch("out_value", o_out_value, want.val);
                    if (o_out_priority !== want.prio)
                        report_mismatch("out_priority", o_out_priority, want.prio);
                    if (o_occupancy !== want.occ)
                        report_mismatch("occupancy", DATA_W'(o_occupancy), DATA_W'(want.occ));
                end
            end
            if (start && !busy)
                awaited_results.push_back(apply_queue_op(t_opcode'(i_opcode),
                                                         i_in_value, i_in_priority));
            n_pending = awaited_results.size();
        end
    end

endmodule

// ===== tb/tb_top.sv =====
module tb_top;
    import spqu_pkg::*;

    localparam int N_RANDOM    = 1000;
    localparam int IDLE_PCT    = 29;
    localparam int STALL_LIMIT = 1000;

    logic                     i_clk = 1'b0;
    logic                     i_rst_n;
    logic                     start;
    logic                     busy;
    logic                     i_opcode;
    logic signed [DATA_W-1:0] i_in_value;
    logic signed [DATA_W-1:0] i_in_priority;
    logic                     o_done;
    logic [1:0]               o_status;
    logic signed [DATA_W-1:0] o_out_value;
    logic signed [DATA_W-1:0] o_out_priority;
    logic [OCC_W-1:0]         o_occupancy;
    int                       n_fail;
    int                       n_pending;
    int                       stall_cycles = 0;
    bit                       idle_ok = 1'b1;

    always begin
        #2 i_clk = 1'b1;
        #2 i_clk = 1'b0;
    end

    sorted_priority_queue_unit u_dut (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .start          (start),
        .busy           (busy),
        .i_opcode       (i_opcode),
        .i_in_value     (i_in_value),
        .i_in_priority  (i_in_priority),
        .o_done         (o_done),
        .o_status       (o_status),
        .o_out_value    (o_out_value),
        .o_out_priority (o_out_priority),
        .o_occupancy    (o_occupancy)
    );

    spqu_checker u_checker (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .start          (start),
        .busy           (busy),
        .i_opcode       (i_opcode),
        .i_in_value     (i_in_value),
        .i_in_priority  (i_in_priority),
        .o_done         (o_done),
        .o_status       (o_status),
        .o_out_value    (o_out_value),
        .o_out_priority (o_out_priority),
        .o_occupancy    (o_occupancy),
        .n_fail         (n_fail),
        .n_pending      (n_pending)
    );

    // watchdog: cycles in a row with no beat in either direction
    always @(posedge i_clk) begin
        if ((start && !busy) || o_done) begin
            stall_cycles <= 0;
        end else if (stall_cycles >= STALL_LIMIT) begin
            $display("CHECKS FAILED");
            $finish;
        end else begin
            stall_cycles <= stall_cycles + 1;
        end
    end

    task automatic send_beat(t_opcode op, logic [DATA_W-1:0] val, logic [DATA_W-1:0] prio);
        while (idle_ok && $urandom_range(0, 99) < IDLE_PCT) begin
            @(negedge i_clk);
            start         <= 1'b0;
            i_opcode      <= 1'($urandom);
            i_in_value    <= DATA_W'($urandom);
            i_in_priority <= DATA_W'($urandom);
        end
        @(negedge i_clk);
        start         <= 1'b1;
        i_opcode      <= op;
        i_in_value    <= val;
        i_in_priority <= prio;
        @(posedge i_clk);
        while (busy)
            @(posedge i_clk);
    endtask

    task automatic drain_wait;
        @(negedge i_clk);
        start <= 1'b0;
        while (n_pending != 0)
            @(negedge i_clk);
    endtask

    // mode 0 full range, 1 a few small values for ties, 2 mostly the extremes and zero
    function automatic logic [DATA_W-1:0] pick_priority(int mode);
        case (mode)
            0: return $urandom;
            1: return $urandom_range(0, 6) - 3;
            default: begin
                case ($urandom_range(0, 3))
                    0: return 32'h8000_0000;
                    1: return 32'h7fff_ffff;
                    2: return '0;
                    default: return $urandom;
                endcase
            end
        endcase
    endfunction

    initial begin
        int      sent;
        int      seg_len;
        int      ins_pct;
        int      prio_mode;
        t_opcode op;
        i_rst_n       = 1'b0;
        start         = 1'b0;
        i_opcode      = 1'b0;
        i_in_value    = '0;
        i_in_priority = '0;
        repeat (7) @(negedge i_clk);
        i_rst_n <= 1'b1;

        // extract from empty, extremes, then ties that must come out oldest first
        send_beat(OP_EXTRACT, $urandom, $urandom);
        send_beat(OP_INSERT, 32'h7fff_ffff, 32'h7fff_ffff);
        send_beat(OP_INSERT, 32'h8000_0000, 32'h8000_0000);
        send_beat(OP_INSERT, 32'hffff_ffff, 32'h0000_0000);
        send_beat(OP_INSERT, 32'h0000_0000, 32'hffff_ffff);
        send_beat(OP_INSERT, 32'h0000_0001, 32'h0000_0000);
        send_beat(OP_INSERT, 32'h0000_0002, 32'h0000_0000);
        send_beat(OP_INSERT, 32'h0000_0003, 32'h8000_0000);
        send_beat(OP_INSERT, 32'h0000_0004, 32'h7fff_ffff);
        repeat (9) send_beat(OP_EXTRACT, $urandom, $urandom);
        drain_wait;

        // most segments lean toward insert or extract so the queue hits full and empty
        sent = 0;
        while (sent < N_RANDOM) begin
            seg_len = $urandom_range(40, 150);
            case ($urandom_range(0, 3))
                0: ins_pct = 95;
                1: ins_pct = 8;
                2: ins_pct = 50;
                default: ins_pct = 65;
            endcase
            prio_mode = $urandom_range(0, 2);
            repeat (seg_len) begin
                idle_ok = !(sent >= 400 && sent < 600);
                if (sent == 700)
                    drain_wait;
                op = ($urandom_range(0, 99) < ins_pct) ? OP_INSERT : OP_EXTRACT;
                send_beat(op, $urandom, pick_priority(prio_mode));
                sent++;
            end
        end

        drain_wait;
        repeat (4) @(negedge i_clk);
        if (n_fail == 0)
            $display("ALL CHECKS PASSED");
        else
            $display("CHECKS FAILED");
        $finish;
    end

endmodule
